/* src/cdst_pkg.sv */
// Shared types, constants, microcode words and calendar helpers of the date stepper.
package cdst_pkg;

    // Field widths and the calendar range
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int AMT_W   = 16;
    localparam int WY_W    = 17;   // working year: holds any year plus an amount
    localparam int MODE_W  = 3;
    localparam int MAX_YEAR = 9999;

    typedef logic [WY_W-1:0] t_wyear;
    localparam t_wyear MAX_YEAR_W = t_wyear'(MAX_YEAR);

    // Division by 100 through a reciprocal; exact for every 14-bit year
    localparam int Q100_W    = 8;
    localparam int SHIFT_100 = 19;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    // Division by 12 through a reciprocal; exact below 2^17
    localparam int Q12_W    = 13;
    localparam int SHIFT_12 = 20;
    localparam logic [16:0] RECIP_12 = 17'd87382;

    // Operation codes carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD       = 3'd0,
        MODE_NEXT       = 3'd1,
        MODE_PREV       = 3'd2,
        MODE_ADD_YEARS  = 3'd3,
        MODE_ADD_MONTHS = 3'd4,
        MODE_ADD_DAYS   = 3'd5
    } t_mode;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP,
        U_Q100,     // quotient of working year by 100
        U_LEAP,     // leap flag of working year
        U_ADDY,     // working year plus amount
        U_TOT,      // month index plus amount
        U_Q12,      // quotient of that total by 12
        U_MON,      // new month and year from total
        U_SETTLE,   // roll to the 1st of next month if the day is missing
        U_NEXT,     // one day forward, count down
        U_PREV,     // one day back
        U_COMMIT,   // store working date, emit result
        U_FAIL      // keep date, emit result with error
    } t_uop;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_LOAD_BAD,
        C_DAY_BAD,
        C_AT_END,
        C_AT_START,
        C_YEAR_OVF,
        C_CNT_ZERO,
        C_WALK_ON
    } t_cond;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // Control word: one micro-op and two prioritised conditional jumps
    typedef struct packed {
        t_uop  op;
        t_cond cond_a;
        t_pc   tgt_a;
        t_cond cond_b;
        t_pc   tgt_b;
    } t_cw;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic load_bad;
        logic day_bad;
        logic at_end;
        logic at_start;
        logic year_ovf;
        logic cnt_zero;
        logic walk_on;
        logic out_block;
    } t_flags;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    // Program addresses
    localparam t_pc PC_LD0    = 5'd0;
    localparam t_pc PC_LD1    = 5'd1;
    localparam t_pc PC_LD2    = 5'd2;
    localparam t_pc PC_NX0    = 5'd3;
    localparam t_pc PC_PV0    = 5'd4;
    localparam t_pc PC_AY0    = 5'd5;
    localparam t_pc PC_AY1    = 5'd6;
    localparam t_pc PC_AY2    = 5'd7;
    localparam t_pc PC_AY3    = 5'd8;
    localparam t_pc PC_AM0    = 5'd9;
    localparam t_pc PC_AM1    = 5'd10;
    localparam t_pc PC_AM2    = 5'd11;
    localparam t_pc PC_AD0    = 5'd12;
    localparam t_pc PC_AD1    = 5'd13;
    localparam t_pc PC_AD2    = 5'd14;
    localparam t_pc PC_AD3    = 5'd15;
    localparam t_pc PC_TL0    = 5'd16;
    localparam t_pc PC_TL1    = 5'd17;
    localparam t_pc PC_COMMIT = 5'd18;
    localparam t_pc PC_FAIL   = 5'd19;

    // Days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Program entry for each operation; unused codes go straight to commit
    function automatic t_pc entry_pc(input logic [MODE_W-1:0] mode);
        t_pc pc;
        unique case (mode)
            MODE_LOAD:       pc = PC_LD0;
            MODE_NEXT:       pc = PC_NX0;
            MODE_PREV:       pc = PC_PV0;
            MODE_ADD_YEARS:  pc = PC_AY0;
            MODE_ADD_MONTHS: pc = PC_AM0;
            MODE_ADD_DAYS:   pc = PC_AD0;
            default:         pc = PC_COMMIT;
        endcase
        return pc;
    endfunction

    // Condition select
    function automatic logic cond_hit(input t_cond c, input t_flags f);
        logic hit;
        unique case (c)
            C_NONE:     hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_LOAD_BAD: hit = f.load_bad;
            C_DAY_BAD:  hit = f.day_bad;
            C_AT_END:   hit = f.at_end;
            C_AT_START: hit = f.at_start;
            C_YEAR_OVF: hit = f.year_ovf;
            C_CNT_ZERO: hit = f.cnt_zero;
            C_WALK_ON:  hit = f.walk_on;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* src/cdst_urom.sv */
// Microprogram store: one control word per step.
module cdst_urom
    import cdst_pkg::*;
(
    input  t_pc i_pc,
    output t_cw o_cw
);

    // Program table
    always_comb begin
        unique case (i_pc)
            // load: range check, leap of the new year, day check
            PC_LD0:    o_cw = '{U_Q100,   C_LOAD_BAD, PC_FAIL, C_NONE,   PC_FAIL};
            PC_LD1:    o_cw = '{U_LEAP,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_LD2:    o_cw = '{U_NOP,    C_DAY_BAD,  PC_FAIL, C_ALWAYS, PC_COMMIT};
            // single day forward / back, then refresh leap
            PC_NX0:    o_cw = '{U_NEXT,   C_AT_END,   PC_FAIL, C_ALWAYS, PC_TL0};
            PC_PV0:    o_cw = '{U_PREV,   C_AT_START, PC_FAIL, C_ALWAYS, PC_TL0};
            // add years
            PC_AY0:    o_cw = '{U_ADDY,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_AY1:    o_cw = '{U_Q100,   C_YEAR_OVF, PC_FAIL, C_NONE,   PC_FAIL};
            PC_AY2:    o_cw = '{U_LEAP,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_AY3:    o_cw = '{U_SETTLE, C_ALWAYS,   PC_COMMIT, C_NONE, PC_FAIL};
            // add months, then share the year check of add years
            PC_AM0:    o_cw = '{U_TOT,    C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_AM1:    o_cw = '{U_Q12,    C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_AM2:    o_cw = '{U_MON,    C_ALWAYS,   PC_AY1,  C_NONE,   PC_FAIL};
            // add days: one day a step, leap refresh at a new year and after the last day
            PC_AD0:    o_cw = '{U_NOP,    C_CNT_ZERO, PC_COMMIT, C_NONE, PC_FAIL};
            PC_AD1:    o_cw = '{U_NEXT,   C_AT_END,   PC_FAIL, C_WALK_ON, PC_AD1};
            PC_AD2:    o_cw = '{U_Q100,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_AD3:    o_cw = '{U_LEAP,   C_ALWAYS,   PC_AD0,  C_NONE,   PC_FAIL};
            // common tail
            PC_TL0:    o_cw = '{U_Q100,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_TL1:    o_cw = '{U_LEAP,   C_ALWAYS,   PC_COMMIT, C_NONE, PC_FAIL};
            PC_COMMIT: o_cw = '{U_COMMIT, C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            PC_FAIL:   o_cw = '{U_FAIL,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
            default:   o_cw = '{U_FAIL,   C_NONE,     PC_FAIL, C_NONE,   PC_FAIL};
        endcase
    end

endmodule

/* src/cdst_seq.sv */
// Sequencer: step counter, conditional jumps and the input handshake.
module cdst_seq
    import cdst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  t_flags            i_flags,
    input  t_cw               i_cw,
    output t_pc               o_pc,
    output t_uop              o_op,
    output logic              o_s_tready
);

    t_seq_state r_state, n_state;
    t_pc        r_pc, n_pc;
    logic       w_end_op;

    assign w_end_op   = (i_cw.op == U_COMMIT) || (i_cw.op == U_FAIL);
    assign o_pc       = r_pc;
    assign o_s_tready = (r_state == S_IDLE);

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_COMMIT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Next step and issued micro-op
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        o_op    = U_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_pc    = entry_pc(i_mode);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // result step waits while the output register is held
                if (!(w_end_op && i_flags.out_block)) begin
                    o_op = i_cw.op;
                    if (w_end_op) begin
                        n_state = S_IDLE;
                    end else if (cond_hit(i_cw.cond_a, i_flags)) begin
                        n_pc = i_cw.tgt_a;
                    end else if (cond_hit(i_cw.cond_b, i_flags)) begin
                        n_pc = i_cw.tgt_b;
                    end else begin
                        n_pc = r_pc + t_pc'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* src/cdst_dp.sv */
// Datapath: current and working date, leap and division units, result register.
module cdst_dp
    import cdst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DAY_W-1:0]  i_load_day,
    input  logic [MON_W-1:0]  i_load_month,
    input  logic [YEAR_W-1:0] i_load_year,
    input  logic [AMT_W-1:0]  i_amount,
    input  t_uop              i_op,
    input  logic              i_m_tready,
    output t_flags            o_flags,
    output logic              o_m_tvalid,
    output logic [DAY_W-1:0]  o_day,
    output logic [MON_W-1:0]  o_month,
    output logic [YEAR_W-1:0] o_year,
    output logic              o_error
);

    // Committed date and its leap flag
    logic [DAY_W-1:0]  r_cur_day,  n_cur_day;
    logic [MON_W-1:0]  r_cur_mon,  n_cur_mon;
    logic [YEAR_W-1:0] r_cur_year, n_cur_year;
    logic              r_cur_leap, n_cur_leap;
    // Working date
    logic [DAY_W-1:0]  r_wd, n_wd;
    logic [MON_W-1:0]  r_wm, n_wm;
    t_wyear            r_wy, n_wy;
    logic              r_wleap, n_wleap;
    logic [AMT_W-1:0]  r_cnt, n_cnt;
    logic [WY_W-1:0]   r_tot, n_tot;
    logic [Q100_W-1:0] r_q100, n_q100;
    logic [Q12_W-1:0]  r_q12, n_q12;
    // Result register
    logic              r_ovalid, n_ovalid;
    logic [DAY_W-1:0]  r_oday, n_oday;
    logic [MON_W-1:0]  r_omon, n_omon;
    logic [YEAR_W-1:0] r_oyear, n_oyear;
    logic              r_oerr, n_oerr;

    logic [DAY_W-1:0]  w_len, w_prev_len;
    logic [26:0]       w_prod100;
    logic [33:0]       w_prod12;
    logic [YEAR_W-1:0] w_rem100;
    logic [MON_W-1:0]  w_rem12;
    logic              w_year_wrap;

    assign w_len       = month_len(r_wm, r_wleap);
    assign w_prev_len  = month_len(r_wm - 4'd1, r_wleap);
    assign w_year_wrap = (r_wd == w_len) && (r_wm == 4'd12);

    // Reciprocal products, each feeding a register
    assign w_prod100 = 27'(r_wy[YEAR_W-1:0]) * 27'(RECIP_100);
    assign w_prod12  = 34'(r_tot) * 34'(RECIP_12);
    assign w_rem100  = r_wy[YEAR_W-1:0] - YEAR_W'(r_q100 * 14'd100);
    assign w_rem12   = MON_W'(r_tot - WY_W'(r_q12) * 17'd12);

    // Status for the sequencer
    always_comb begin
        o_flags.load_bad  = (r_wy == '0) || (r_wy > MAX_YEAR_W) || (r_wm == '0)
                            || (r_wm > 4'd12) || (r_wd == '0);
        o_flags.day_bad   = (r_wd > w_len);
        o_flags.at_end    = w_year_wrap && (r_wy >= MAX_YEAR_W);
        o_flags.at_start  = (r_wd == 5'd1) && (r_wm == 4'd1) && (r_wy <= t_wyear'(1));
        o_flags.year_ovf  = (r_wy > MAX_YEAR_W);
        o_flags.cnt_zero  = (r_cnt == '0);
        o_flags.walk_on   = (r_cnt != AMT_W'(1)) && !w_year_wrap;
        o_flags.out_block = r_ovalid && !i_m_tready;
    end

    // Micro-op execution
    always_comb begin
        n_cur_day  = r_cur_day;
        n_cur_mon  = r_cur_mon;
        n_cur_year = r_cur_year;
        n_cur_leap = r_cur_leap;
        n_wd       = r_wd;
        n_wm       = r_wm;
        n_wy       = r_wy;
        n_wleap    = r_wleap;
        n_cnt      = r_cnt;
        n_tot      = r_tot;
        n_q100     = r_q100;
        n_q12      = r_q12;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_oday     = r_oday;
        n_omon     = r_omon;
        n_oyear    = r_oyear;
        n_oerr     = r_oerr;

        if (i_accept) begin
            // load works on the new fields, the rest on the held date
            if (i_mode == MODE_LOAD) begin
                n_wd = i_load_day;
                n_wm = i_load_month;
                n_wy = WY_W'(i_load_year);
            end else begin
                n_wd = r_cur_day;
                n_wm = r_cur_mon;
                n_wy = WY_W'(r_cur_year);
            end
            n_wleap = r_cur_leap;
            n_cnt   = i_amount;
        end

        unique case (i_op)
            U_NOP: ;
            U_Q100: n_q100 = w_prod100[SHIFT_100 +: Q100_W];
            U_LEAP: n_wleap = (r_wy[1:0] == 2'd0)
                              && ((w_rem100 != '0) || (r_q100[1:0] == 2'd0));
            U_ADDY: n_wy = r_wy + WY_W'(r_cnt);
            U_TOT:  n_tot = WY_W'(r_wm - 4'd1) + WY_W'(r_cnt);
            U_Q12:  n_q12 = w_prod12[SHIFT_12 +: Q12_W];
            U_MON: begin
                n_wm = w_rem12 + 4'd1;
                n_wy = r_wy + WY_W'(r_q12);
            end
            U_SETTLE: begin
                if (r_wd > w_len) begin
                    n_wm = r_wm + 4'd1;
                    n_wd = 5'd1;
                end
            end
            U_NEXT: begin
                n_cnt = r_cnt - AMT_W'(1);
                if (r_wd < w_len) begin
                    n_wd = r_wd + 5'd1;
                end else if (r_wm < 4'd12) begin
                    n_wm = r_wm + 4'd1;
                    n_wd = 5'd1;
                end else begin
                    n_wy = r_wy + t_wyear'(1);
                    n_wm = 4'd1;
                    n_wd = 5'd1;
                end
            end
            U_PREV: begin
                if (r_wd > 5'd1) begin
                    n_wd = r_wd - 5'd1;
                end else if (r_wm > 4'd1) begin
                    n_wm = r_wm - 4'd1;
                    n_wd = w_prev_len;
                end else begin
                    n_wy = r_wy - t_wyear'(1);
                    n_wm = 4'd12;
                    n_wd = 5'd31;
                end
            end
            U_COMMIT: begin
                n_cur_day  = r_wd;
                n_cur_mon  = r_wm;
                n_cur_year = r_wy[YEAR_W-1:0];
                n_cur_leap = r_wleap;
                n_oday     = r_wd;
                n_omon     = r_wm;
                n_oyear    = r_wy[YEAR_W-1:0];
                n_oerr     = 1'b0;
                n_ovalid   = 1'b1;
            end
            U_FAIL: begin
                n_oday   = r_cur_day;
                n_omon   = r_cur_mon;
                n_oyear  = r_cur_year;
                n_oerr   = 1'b1;
                n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    // Held date and result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day  <= 5'd1;
            r_cur_mon  <= 4'd1;
            r_cur_year <= 14'd1;
            r_cur_leap <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_cur_day  <= n_cur_day;
            r_cur_mon  <= n_cur_mon;
            r_cur_year <= n_cur_year;
            r_cur_leap <= n_cur_leap;
            r_ovalid   <= n_ovalid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_wd    <= n_wd;
        r_wm    <= n_wm;
        r_wy    <= n_wy;
        r_wleap <= n_wleap;
        r_cnt   <= n_cnt;
        r_tot   <= n_tot;
        r_q100  <= n_q100;
        r_q12   <= n_q12;
        r_oday  <= n_oday;
        r_omon  <= n_omon;
        r_oyear <= n_oyear;
        r_oerr  <= n_oerr;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_day      = r_oday;
    assign o_month    = r_omon;
    assign o_year     = r_oyear;
    assign o_error    = r_oerr;

endmodule

/* src/calendar_date_stepper_top.sv */
// Top level of the Gregorian date stepper: sequencer, microprogram and datapath.
//
//  channel  dir  beat fields (low bit first)
//  s_axis   in   tuser: mode[2:0]; tdata: load_day, load_month, load_year, amount
//  m_axis   out  tuser: error[0];  tdata: day, month, year
//
// Each item runs its microprogram from the entry of its mode to a commit or fail step;
// unused modes go straight to commit. Add days walks one day a step and refreshes the
// leap flag at each exit from the walking loop (one at each new year crossed, and one
// after the last day unless that day opens a new year). The next item is taken the cycle
// after the last step. Reset gives 1 January of year 1. A held result beat stalls only
// the final step; the next item is still taken while that beat waits.
module calendar_date_stepper_top
    import cdst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9],
                                     // amount[38:23], zero[39]
    input  logic [2:0]  i_s_tuser,   // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // day[4:0], month[8:5], year[22:9], zero[23]
    output logic [0:0]  o_m_tuser    // error[0]
);

    logic              w_accept;
    t_pc               w_pc;
    t_cw               w_cw;
    t_uop              w_op;
    t_flags            w_flags;
    logic [DAY_W-1:0]  w_day;
    logic [MON_W-1:0]  w_month;
    logic [YEAR_W-1:0] w_year;
    logic              w_error;

    assign w_accept = i_s_tvalid && o_s_tready;

    cdst_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_mode     (i_s_tuser),
        .i_flags    (w_flags),
        .i_cw       (w_cw),
        .o_pc       (w_pc),
        .o_op       (w_op),
        .o_s_tready (o_s_tready)
    );

    cdst_urom u_urom (
        .i_pc (w_pc),
        .o_cw (w_cw)
    );

    cdst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_mode       (i_s_tuser),
        .i_load_day   (i_s_tdata[4:0]),
        .i_load_month (i_s_tdata[8:5]),
        .i_load_year  (i_s_tdata[22:9]),
        .i_amount     (i_s_tdata[38:23]),
        .i_op         (w_op),
        .i_m_tready   (i_m_tready),
        .o_flags      (w_flags),
        .o_m_tvalid   (o_m_tvalid),
        .o_day        (w_day),
        .o_month      (w_month),
        .o_year       (w_year),
        .o_error      (w_error)
    );

    // Output beat packing
    assign o_m_tdata = {1'b0, w_year, w_month, w_day};
    assign o_m_tuser = w_error;

    // One item in flight: an accepted beat closes the input until its result
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input taken while an item is still in work");

    // Every result carries a real month and a non-zero day
    a_date_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_month >= 4'd1) && (w_month <= 4'd12) && (w_day != '0))
        else $error("result date field out of range");

    // Every result year stays inside the calendar range
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_year != '0) && (WY_W'(w_year) <= MAX_YEAR_W))
        else $error("result year out of range");

endmodule

/* bench/calendar_date_stepper_checker.sv */
// Result checker of the date stepper: tracks the calendar date and compares each output beat.
`timescale 1ns / 1ps
module calendar_date_stepper_checker
    import cdst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9],
                                     // amount[38:23], zero[39]
    input  logic [2:0]  i_s_tuser,   // mode[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // day[4:0], month[8:5], year[22:9], zero[23]
    input  logic [0:0]  i_m_tuser,   // error[0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_error_count
);

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              error;
    } t_date_beat;

    // Tracked date and the beats still owed by the block
    int         cal_day;
    int         cal_month;
    int         cal_year;
    t_date_beat dates_due[$];
    int         fails;
    int         results;
    int         flagged;

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // One day on; refuses to pass the last year
    function automatic bit day_forward(inout int d, inout int m, inout int y);
        if (d < days_in_month(m, y)) begin
            d++;
            return 1'b1;
        end
        if (m < 12) begin
            m++;
            d = 1;
            return 1'b1;
        end
        if (y >= MAX_YEAR)
            return 1'b0;
        y++;
        m = 1;
        d = 1;
        return 1'b1;
    endfunction

    // One day back; refuses to go before year 1
    function automatic bit day_back(inout int d, inout int m, inout int y);
        if (d > 1) begin
            d--;
            return 1'b1;
        end
        if (m > 1) begin
            m--;
            d = days_in_month(m, y);
            return 1'b1;
        end
        if (y <= 1)
            return 1'b0;
        y--;
        m = 12;
        d = 31;
        return 1'b1;
    endfunction

    // Day missing in the target month: first of the month after (never past December)
    function automatic void roll_missing_day(inout int d, inout int m, input int y);
        if (d > days_in_month(m, y)) begin
            m++;
            d = 1;
        end
    endfunction

    // Apply one operation to the tracked date and form the beat it must produce
    function automatic t_date_beat step_date(input logic [MODE_W-1:0] mode, input int ld,
                                             input int lm, input int ly, input int amt);
        int         d;
        int         m;
        int         y;
        int         total;
        bit         ok;
        t_date_beat beat;
        d  = cal_day;
        m  = cal_month;
        y  = cal_year;
        ok = 1'b1;
        unique case (mode)
            MODE_LOAD: begin
                if (ly < 1 || ly > MAX_YEAR || lm < 1 || lm > 12 ||
                    ld < 1 || ld > days_in_month(lm, ly)) begin
                    ok = 1'b0;
                end else begin
                    d = ld;
                    m = lm;
                    y = ly;
                end
            end
            MODE_NEXT: ok = day_forward(d, m, y);
            MODE_PREV: ok = day_back(d, m, y);
            MODE_ADD_YEARS: begin
                y += amt;
                if (y > MAX_YEAR)
                    ok = 1'b0;
                else
                    roll_missing_day(d, m, y);
            end
            MODE_ADD_MONTHS: begin
                total = (m - 1) + amt;
                y += total / 12;
                m = total % 12 + 1;
                if (y > MAX_YEAR)
                    ok = 1'b0;
                else
                    roll_missing_day(d, m, y);
            end
            MODE_ADD_DAYS: begin
                for (int n = 0; n < amt && ok; n++)
                    ok = day_forward(d, m, y);
            end
            default: ;
        endcase
        // a failed operation keeps the date from before it
        if (ok) begin
            cal_day   = d;
            cal_month = m;
            cal_year  = y;
        end
        beat.day   = DAY_W'(cal_day);
        beat.month = MON_W'(cal_month);
        beat.year  = YEAR_W'(cal_year);
        beat.error = !ok;
        return beat;
    endfunction

    // Output beats are retired before the input beat of the same edge is predicted
    always @(posedge i_clk) begin
        t_date_beat seen;
        t_date_beat due;
        if (!i_rst_n) begin
            cal_day   = 1;
            cal_month = 1;
            cal_year  = 1;
            dates_due.delete();
            fails     = 0;
            results   = 0;
            flagged   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.day   = i_m_tdata[4:0];
                seen.month = i_m_tdata[8:5];
                seen.year  = i_m_tdata[22:9];
                seen.error = i_m_tuser[0];
                results++;
                if (seen.error === 1'b1)
                    flagged++;
                if (dates_due.size() == 0) begin
                    if (fails < 10)
                        $display("result %0d arrived with none outstanding: %0d/%0d/%0d err=%0b",
                                 results, seen.day, seen.month, seen.year,
                                 seen.error);
                    fails++;
                end else begin
                    due = dates_due.pop_front();
                    if (seen.day !== due.day || seen.month !== due.month ||
                        seen.year !== due.year || seen.error !== due.error) begin
                        if (fails < 10)
                            $display({"result %0d: expected %0d/%0d/%0d err=%0b, ",
                                      "got %0d/%0d/%0d err=%0b"},
                                     results, due.day, due.month, due.year, due.error,
                                     seen.day, seen.month, seen.year, seen.error);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                dates_due.push_back(step_date(i_s_tuser, i_s_tdata[4:0], i_s_tdata[8:5],
                                              i_s_tdata[22:9], i_s_tdata[38:23]));
        end
        o_fail_count   <= fails;
        o_pending      <= dates_due.size();
        o_result_count <= results;
        o_error_count  <= flagged;
    end

endmodule

/* bench/calendar_date_stepper_top_test.sv */
// Testbench top of the date stepper: clock, reset, operation stimulus and verdict.
`timescale 1ns / 1ps
module calendar_date_stepper_top_test;
    import cdst_pkg::*;

    // Codes the block does not define; they must leave the date alone
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int RANDOM_OPS  = 2000;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 40;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // load_day[4:0], load_month[8:5], load_year[22:9],
                                  // amount[38:23], zero[39]
    logic [2:0]  s_tuser  = '0;   // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // day[4:0], month[8:5], year[22:9], zero[23]
    logic [0:0]  m_tuser;         // error[0]

    int fail_count;
    int pending;
    int result_count;
    int error_count;
    int ops_sent    = 0;
    int cycle_count = 0;
    bit send_calm   = 1'b0;
    bit take_calm   = 1'b0;

    calendar_date_stepper_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    calendar_date_stepper_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_error_count  (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall before each beat, with calm stretches
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready)) @(posedge clk);
        end
    end

    // One operation beat, after a random gap
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DAY_W-1:0] ld,
                           input logic [MON_W-1:0] lm, input logic [YEAR_W-1:0] ly,
                           input logic [AMT_W-1:0] amt);
        int gap;
        if ($urandom_range(0, 49) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, amt, ly, lm, ld};
        do @(posedge clk); while (!s_tready);
        ops_sent++;
    endtask

    // Hold off until every owed result beat is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Years near the range ends, century and leap years, or anywhere
    function automatic logic [YEAR_W-1:0] pick_year();
        int y;
        case ($urandom_range(0, 4))
            0:       y = $urandom_range(1, 4);
            1:       y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
            2:       y = 100 * $urandom_range(1, 99);
            3:       y = 4 * $urandom_range(1, 2499);
            default: y = $urandom_range(1, MAX_YEAR);
        endcase
        return YEAR_W'(y);
    endfunction

    initial begin
        int                 pick;
        logic [DAY_W-1:0]   ld;
        logic [MON_W-1:0]   lm;
        logic [YEAR_W-1:0]  ly;
        logic [AMT_W-1:0]   amt;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range ends, leap rules, missing days, zero amounts, spare codes
        send_op(MODE_NEXT,       0,  0,     0,     0);
        send_op(MODE_PREV,       0,  0,     0,     0);
        send_op(MODE_PREV,       0,  0,     0,     0);      // before 1 January of year 1
        send_op(MODE_LOAD,       31, 12,    9999,  0);
        send_op(MODE_NEXT,       0,  0,     0,     0);      // past the last day
        send_op(MODE_ADD_DAYS,   0,  0,     0,     1);
        send_op(MODE_ADD_MONTHS, 0,  0,     0,     1);      // month sum exactly twelve
        send_op(MODE_ADD_YEARS,  0,  0,     0,     0);
        send_op(MODE_ADD_MONTHS, 0,  0,     0,     0);
        send_op(MODE_ADD_DAYS,   0,  0,     0,     0);
        send_op(MODE_LOAD,       29, 2,     1900,  0);      // century, not leap
        send_op(MODE_LOAD,       29, 2,     2000,  0);      // four-hundred rule
        send_op(MODE_ADD_YEARS,  0,  0,     0,     1);      // 29 Feb missing next year
        send_op(MODE_PREV,       0,  0,     0,     0);
        send_op(MODE_LOAD,       0,  5,     2000,  0);
        send_op(MODE_LOAD,       10, 0,     2000,  0);
        send_op(MODE_LOAD,       10, 5,     10000, 0);
        send_op(MODE_LOAD,       31, 15,    16383, 16'hffff);
        send_op(MODE_LOAD,       31, 1,     2023,  0);
        send_op(MODE_ADD_MONTHS, 0,  0,     0,     1);      // 31 Feb missing
        send_op(MODE_ADD_MONTHS, 0,  0,     0,     12);
        send_op(MODE_ADD_MONTHS, 0,  0,     0,     16'hffff);
        send_op(MODE_ADD_YEARS,  0,  0,     0,     16'hffff);
        send_op(MODE_SPARE_LO,   5,  5,     5,     5);
        send_op(MODE_SPARE_HI,   31, 15,    16383, 16'hffff);
        send_op(MODE_ADD_DAYS,   0,  0,     0,     16'hffff);
        wait_drained();

        // Random: mostly valid dates and short steps, some garbage and long walks
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (k % 500 == 250)
                wait_drained();
            ld   = DAY_W'($urandom);
            lm   = MON_W'($urandom);
            ly   = YEAR_W'($urandom);
            amt  = AMT_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                ld = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom_range(28, 31))
                                                 : DAY_W'($urandom_range(1, 28));
                send_op(MODE_LOAD, ld, MON_W'($urandom_range(1, 12)), pick_year(), amt);
            end else if (pick < 25) begin
                send_op(MODE_LOAD, ld, lm, ly, amt);
            end else if (pick < 43) begin
                send_op(MODE_NEXT, ld, lm, ly, amt);
            end else if (pick < 59) begin
                send_op(MODE_PREV, ld, lm, ly, amt);
            end else if (pick < 69) begin
                if ($urandom_range(0, 7) != 0)
                    amt = AMT_W'($urandom_range(0, 40));
                send_op(MODE_ADD_YEARS, ld, lm, ly, amt);
            end else if (pick < 81) begin
                if ($urandom_range(0, 7) != 0)
                    amt = AMT_W'($urandom_range(0, 60));
                send_op(MODE_ADD_MONTHS, ld, lm, ly, amt);
            end else if (pick < 96) begin
                // the walk costs a cycle a day, so long ones stay rare
                if ($urandom_range(0, 99) != 0)
                    amt = AMT_W'($urandom_range(0, 400));
                send_op(MODE_ADD_DAYS, ld, lm, ly, amt);
            end else begin
                send_op(pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO, ld, lm, ly, amt);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Drove %0d date operations over every mode and the spare codes; %0d beats checked.",
                 ops_sent, result_count);
        $display("%0d of the checked beats carried the error flag.", error_count);
        if (fail_count + pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
